### hdl/two_key_sorted_priority_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Concurrent checks that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef TWO_KEY_SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define TWO_KEY_SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge out of reset.
`define TKSQ_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("queue invariant violated");

// When the antecedent holds, the consequent holds in the next cycle.
`define TKSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("queue next-cycle check violated");

`else

`define TKSQ_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define TKSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### hdl/tksq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Operation codes and the beat and cell control types.
// ----------------------------------------------------------------------------
package tksq_pkg;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    typedef struct packed {
        logic [31:0] tag;
        logic [7:0]  priority_key;
        logic [7:0]  age;
    } t_entry;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] entry_tag;
        logic [7:0]  entry_priority;
        logic [7:0]  entry_age;
    } t_in_item;

    typedef struct packed {
        logic        queue_empty;
        logic [31:0] head_tag;
        logic [7:0]  head_priority;
        logic [7:0]  head_age;
        logic [4:0]  occupancy;
        logic        overflow;
    } t_out_item;

    // Broadcast to every cell for the beat being accepted.
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

endpackage

### hdl/tksq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry, compares it with a pushed entry and shifts with neighbors.
// ----------------------------------------------------------------------------
module tksq_cell (
    input  logic                i_clk,
    input  tksq_pkg::t_cell_ctrl i_ctrl,
    input  tksq_pkg::t_entry    i_new_entry,
    input  logic                i_occupied,
    input  tksq_pkg::t_entry    i_left_entry,
    input  logic                i_left_slot,
    input  tksq_pkg::t_entry    i_right_entry,
    output tksq_pkg::t_entry    o_entry,
    output tksq_pkg::t_entry    o_next_entry,
    output logic                o_slot
);

    tksq_pkg::t_entry r_entry;
    tksq_pkg::t_entry n_entry;
    logic             w_slot;

    // The new entry belongs here or earlier when this cell is free or its entry
    // ranks at or below the new one. Along the sorted chain this is monotonic.
    always_comb begin
        w_slot = !i_occupied
              || (r_entry.priority_key < i_new_entry.priority_key)
              || ((r_entry.priority_key == i_new_entry.priority_key)
                  && (r_entry.age <= i_new_entry.age));
    end

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.push) begin
            if (i_left_slot) begin
                n_entry = i_left_entry;
            end else if (w_slot) begin
                n_entry = i_new_entry;
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry      = r_entry;
    assign o_next_entry = n_entry;
    assign o_slot       = w_slot;

endmodule

### hdl/two_key_sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Two-key sorted priority queue
// A chain of compare-and-shift cells kept in priority, then age, order.
// ----------------------------------------------------------------------------
//  Channel  Handshake                 Beat
//  input    i_in_valid / o_in_ready   i_in_item  (operation, tag, priority, age)
//  output   o_out_valid / i_out_ready o_out_item (head, occupancy, overflow)
//
// For every beat, all cells compare against the pushed entry and
// shift in parallel, and the result is registered in the same edge.
// One beat per cycle is sustained while the output side takes its results.
// The output register stalls the input only while a result waits untaken.
// Reset clears the entry count and the output valid; cell contents are not reset.
`include "two_key_sorted_priority_queue_unit_macros.svh"

module two_key_sorted_priority_queue_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tksq_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tksq_pkg::t_out_item o_out_item
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    tksq_pkg::t_out_item r_result;
    tksq_pkg::t_out_item n_result;

    logic                w_accept;
    logic                w_full;
    logic                w_empty;
    logic                w_is_push;
    logic                w_is_pop;
    logic                w_push_req;
    logic                w_pop_req;
    tksq_pkg::t_cell_ctrl w_ctrl;
    tksq_pkg::t_entry    w_new_entry;

    tksq_pkg::t_entry    w_entry      [QUEUE_DEPTH];
    tksq_pkg::t_entry    w_next_entry [QUEUE_DEPTH];
    logic                w_slot       [QUEUE_DEPTH];
    logic                w_occupied   [QUEUE_DEPTH];
    tksq_pkg::t_entry    w_left_entry [QUEUE_DEPTH];
    logic                w_left_slot  [QUEUE_DEPTH];
    tksq_pkg::t_entry    w_right_entry[QUEUE_DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty    = (r_count == '0);

    always_comb begin
        w_is_push = 1'b0;
        w_is_pop  = 1'b0;
        case (i_in_item.operation)
            tksq_pkg::OP_PUSH: w_is_push = 1'b1;
            tksq_pkg::OP_POP:  w_is_pop  = 1'b1;
            tksq_pkg::OP_PEEK: w_is_pop  = 1'b0;
            default:           w_is_pop  = 1'b0;
        endcase
    end

    assign w_push_req  = w_accept && w_is_push;
    assign w_pop_req   = w_accept && w_is_pop;
    assign w_ctrl.push = w_push_req && !w_full;
    assign w_ctrl.pop  = w_pop_req && !w_empty;

    assign w_new_entry.tag          = i_in_item.entry_tag;
    assign w_new_entry.priority_key = i_in_item.entry_priority;
    assign w_new_entry.age          = i_in_item.entry_age;

    // Neighbor wiring of the chain; the ends see a non-inserting left and an
    // arbitrary right entry, which only ever lands in a cell that becomes free.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_occupied[i] = (r_count > CNT_W'(i));
            if (i == 0) begin
                w_left_entry[i] = w_new_entry;
                w_left_slot[i]  = 1'b0;
            end else begin
                w_left_entry[i] = w_entry[i-1];
                w_left_slot[i]  = w_slot[i-1];
            end
            if (i == QUEUE_DEPTH - 1) begin
                w_right_entry[i] = w_new_entry;
            end else begin
                w_right_entry[i] = w_entry[i+1];
            end
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        tksq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_new_entry   (w_new_entry),
            .i_occupied    (w_occupied[g]),
            .i_left_entry  (w_left_entry[g]),
            .i_left_slot   (w_left_slot[g]),
            .i_right_entry (w_right_entry[g]),
            .o_entry       (w_entry[g]),
            .o_next_entry  (w_next_entry[g]),
            .o_slot        (w_slot[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        n_result.queue_empty = (n_count == '0);
        if (n_count == '0) begin
            n_result.head_tag      = '0;
            n_result.head_priority = '0;
            n_result.head_age      = '0;
        end else begin
            n_result.head_tag      = w_next_entry[0].tag;
            n_result.head_priority = w_next_entry[0].priority_key;
            n_result.head_age      = w_next_entry[0].age;
        end
        n_result.occupancy = 5'(n_count);
        n_result.overflow  = w_push_req && w_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_result;

    `TKSQ_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(QUEUE_DEPTH))
    `TKSQ_ASSERT_ALWAYS(a_empty_flag, i_clk, i_rst_n, !r_out_valid || r_result.queue_empty == w_empty)
    `TKSQ_ASSERT_NEXT(a_drop_flag, i_clk, i_rst_n, w_push_req && w_full, r_result.overflow && w_full)
    `TKSQ_ASSERT_NEXT(a_pop_empty, i_clk, i_rst_n, w_pop_req && w_empty, w_empty && !r_result.overflow)

endmodule

### tb/tksq_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Result checker for the sorted priority queue
// Watches both channels, keeps its own sorted copy of the queue, predicts
// the result of every accepted input beat and compares each output beat
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tksq_result_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  tksq_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  tksq_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending_results
);

    localparam int REPORT_LIMIT = 10;

    tksq_pkg::t_entry    sorted_entries [QUEUE_DEPTH];
    int unsigned         stored_count;
    tksq_pkg::t_out_item expected_heads [$];
    int                  fail_count;

    // Applies one operation to the local queue copy and returns the
    // head, occupancy and overflow the block should report for it.
    function automatic tksq_pkg::t_out_item apply_operation(input tksq_pkg::t_in_item beat);
        tksq_pkg::t_out_item result;
        int unsigned         slot;
        int unsigned         i;
        result = '0;
        if (beat.operation == tksq_pkg::OP_PUSH) begin
            if (stored_count >= QUEUE_DEPTH) begin
                result.overflow = 1'b1;
            end else begin
                // Skip past entries that outrank the new one; on an exact tie
                // the new entry lands in front of the stored one.
                slot = 0;
                while (slot < stored_count &&
                       !(sorted_entries[slot].priority_key < beat.entry_priority ||
                         (sorted_entries[slot].priority_key == beat.entry_priority &&
                          sorted_entries[slot].age <= beat.entry_age))) begin
                    slot++;
                end
                for (i = stored_count; i > slot; i--) begin
                    sorted_entries[i] = sorted_entries[i - 1];
                end
                sorted_entries[slot] = '{tag: beat.entry_tag,
                                         priority_key: beat.entry_priority,
                                         age: beat.entry_age};
                stored_count++;
            end
        end else if (beat.operation == tksq_pkg::OP_POP && stored_count != 0) begin
            for (i = 1; i < stored_count; i++) begin
                sorted_entries[i - 1] = sorted_entries[i];
            end
            stored_count--;
        end
        if (stored_count == 0) begin
            result.queue_empty = 1'b1;
        end else begin
            result.head_tag      = sorted_entries[0].tag;
            result.head_priority = sorted_entries[0].priority_key;
            result.head_age      = sorted_entries[0].age;
        end
        result.occupancy = 5'(stored_count);
        return result;
    endfunction

    task automatic check_field(input string field_name, input logic [31:0] expected_val,
                               input logic [31:0] actual_val, inout bit field_bad);
        if (actual_val !== expected_val) begin
            field_bad = 1'b1;
            if (fail_count < REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, field_name, expected_val, actual_val);
            end
        end
    endtask

    always @(posedge i_clk) begin
        tksq_pkg::t_out_item expected;
        bit                  result_bad;
        if (!i_rst_n) begin
            stored_count = 0;
            expected_heads.delete();
            fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_heads.size() == 0) begin
                    if (fail_count < REPORT_LIMIT) begin
                        $display("%0t: output beat with nothing expected: %p",
                                 $time, i_out_item);
                    end
                    fail_count++;
                end else begin
                    expected   = expected_heads.pop_front();
                    result_bad = 1'b0;
                    check_field("queue_empty", 32'(expected.queue_empty),
                                32'(i_out_item.queue_empty), result_bad);
                    check_field("head_tag", expected.head_tag,
                                i_out_item.head_tag, result_bad);
                    check_field("head_priority", 32'(expected.head_priority),
                                32'(i_out_item.head_priority), result_bad);
                    check_field("head_age", 32'(expected.head_age),
                                32'(i_out_item.head_age), result_bad);
                    check_field("occupancy", 32'(expected.occupancy),
                                32'(i_out_item.occupancy), result_bad);
                    check_field("overflow", 32'(expected.overflow),
                                32'(i_out_item.overflow), result_bad);
                    if (result_bad) begin
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_heads.push_back(apply_operation(i_in_item));
            end
        end
        o_fail_count      = fail_count;
        o_pending_results = expected_heads.size();
    end

endmodule

### tb/tb_two_key_sorted_priority_queue_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the two-key sorted priority queue
// Drives directed corner cases and then bursts of random push, pop, peek and
// reserved-code beats with random gaps, while the output side stalls on its own
// pattern. A separate checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_two_key_sorted_priority_queue_unit;

    localparam int         DEPTH          = 16;
    localparam logic [1:0] OP_RESERVED    = 2'd3;
    localparam int         RANDOM_BEATS   = 700;
    localparam int         LONG_HOLD      = 80;
    localparam int         HOLD_AFTER     = 150;
    localparam int         IDLE_LIMIT     = 2000;
    localparam int         SETTLE_CYCLES  = 10;

    // Keys for the directed fill: extremes, exact ties and near ties.
    localparam logic [0:15][7:0] FILL_PRIORITY = '{
        8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd128, 8'd128, 8'd128,
        8'd1, 8'd254, 8'd128, 8'd64, 8'd64, 8'd200, 8'd0, 8'd255};
    localparam logic [0:15][7:0] FILL_AGE = '{
        8'd255, 8'd0, 8'd0, 8'd255, 8'd7, 8'd7, 8'd8, 8'd6,
        8'd1, 8'd254, 8'd128, 8'd200, 8'd200, 8'd64, 8'd0, 8'd255};

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } t_traffic_mix;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    tksq_pkg::t_in_item  in_item     = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    tksq_pkg::t_out_item out_item;

    logic                in_beat_taken = 1'b0;
    int                  beats_taken   = 0;
    int                  idle_cycles   = 0;
    int                  fail_count;
    int                  pending_results;

    two_key_sorted_priority_queue_unit #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    tksq_result_checker #(
        .QUEUE_DEPTH(DEPTH)
    ) checker_inst (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_in_item        (in_item),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_item       (out_item),
        .o_fail_count     (fail_count),
        .o_pending_results(pending_results)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Handshake bookkeeping and the watchdog on accepted beats.
    always @(posedge clk) begin
        in_beat_taken <= in_valid && in_ready;
        if (in_valid && in_ready) begin
            beats_taken <= beats_taken + 1;
        end
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic tksq_pkg::t_in_item make_beat(input logic [1:0] operation,
                                                     input logic [31:0] tag,
                                                     input logic [7:0] priority_key,
                                                     input logic [7:0] age);
        tksq_pkg::t_in_item beat;
        beat.operation      = operation;
        beat.entry_tag      = tag;
        beat.entry_priority = priority_key;
        beat.entry_age      = age;
        return beat;
    endfunction

    // A quarter of the keys come from 0 to 3 and a quarter are 0 or 255, so that ties are common.
    function automatic logic [7:0] random_key();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic tksq_pkg::t_in_item random_beat(input t_traffic_mix mix);
        int         roll;
        int         push_share;
        int         pop_share;
        logic [1:0] operation;
        roll       = $urandom_range(0, 99);
        push_share = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 15 : 45;
        pop_share  = (mix == MIX_FILL) ? 15 : (mix == MIX_DRAIN) ? 75 : 45;
        if (roll < push_share) begin
            operation = tksq_pkg::OP_PUSH;
        end else if (roll < push_share + pop_share) begin
            operation = tksq_pkg::OP_POP;
        end else if (roll < 98) begin
            operation = tksq_pkg::OP_PEEK;
        end else begin
            operation = OP_RESERVED;
        end
        return make_beat(operation, $urandom, random_key(), random_key());
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_beat(input tksq_pkg::t_in_item beat);
        in_valid <= 1'b1;
        in_item  <= beat;
        do begin
            @(negedge clk);
        end while (!in_beat_taken);
    endtask

    task automatic pause_input(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Output side: changing stall patterns, plus one long hold-off that
    // lets a result wait untaken and back-pressure the block's input.
    initial begin
        int  pattern;
        int  pattern_left;
        bit  hold_done;
        bit  toggle_phase;
        pattern      = 0;
        pattern_left = 0;
        hold_done    = 1'b0;
        toggle_phase = 1'b0;
        @(posedge rst_n);
        forever begin
            if (!hold_done && beats_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                repeat (LONG_HOLD) begin
                    out_ready <= 1'b0;
                    @(negedge clk);
                end
            end
            if (pattern_left == 0) begin
                pattern      = $urandom_range(0, 3);
                pattern_left = $urandom_range(10, 60);
            end
            pattern_left--;
            toggle_phase = ~toggle_phase;
            case (pattern)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= toggle_phase;
            endcase
            @(negedge clk);
        end
    end

    initial begin
        t_traffic_mix mix;
        int           sent;
        int           mix_left;
        int           burst;
        int           idx;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: operations on an empty queue, a full fill, a dropped push,
        // and the reserved code, a peek and a pop on a full queue.
        send_beat(make_beat(tksq_pkg::OP_PEEK, $urandom, 8'd9, 8'd9));
        send_beat(make_beat(tksq_pkg::OP_POP, $urandom, 8'd9, 8'd9));
        send_beat(make_beat(OP_RESERVED, $urandom, 8'd9, 8'd9));
        for (idx = 0; idx < DEPTH; idx++) begin
            send_beat(make_beat(tksq_pkg::OP_PUSH,
                                (idx == 0) ? 32'hFFFF_FFFF : (idx == 1) ? 32'h0 : $urandom,
                                FILL_PRIORITY[idx], FILL_AGE[idx]));
        end
        send_beat(make_beat(tksq_pkg::OP_PUSH, $urandom, 8'd255, 8'd255));
        send_beat(make_beat(OP_RESERVED, $urandom, 8'd0, 8'd0));
        send_beat(make_beat(tksq_pkg::OP_PEEK, $urandom, 8'd0, 8'd0));
        send_beat(make_beat(tksq_pkg::OP_POP, $urandom, 8'd0, 8'd0));

        // Random bursts, switching between filling, draining and mixed traffic.
        mix      = MIX_DRAIN;
        mix_left = $urandom_range(20, 60);
        sent     = 0;
        while (sent < RANDOM_BEATS) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 24);
            for (idx = 0; idx < burst && sent < RANDOM_BEATS; idx++) begin
                if (mix_left == 0) begin
                    mix      = t_traffic_mix'($urandom_range(0, 2));
                    mix_left = $urandom_range(20, 60);
                end
                mix_left--;
                send_beat(random_beat(mix));
                sent++;
            end
            if ($urandom_range(0, 3) != 0) begin
                pause_input($urandom_range(1, 6));
            end
        end
        in_valid <= 1'b0;

        while (pending_results != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
